// File: sv/page_bitmap_allocator_unit_assert.svh
// ----------------------------------------------------------------------------
// Page bitmap allocator assertion macros
// Shared concurrent assertion forms for the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef PAGE_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH
`define PAGE_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define PBA_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PBA_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg
// Sizes, codes and shared types of the page bitmap allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

   localparam int MAP_PAGES = 32768;
   localparam int PAGE_BITS = 12;
   localparam int MAP_WORDS = (MAP_PAGES + 31) / 32;
   localparam int WIDX_W    = $clog2(MAP_WORDS);
   localparam int KW        = $clog2(MAP_PAGES + 1);

   localparam int ACTION_W  = 3;
   localparam int ADDR_W    = 32;
   localparam int RUN_W     = 16;
   localparam int ALIGN_W   = 5;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 16;
   localparam int BASE_W    = 20;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DW    = 20;

   localparam logic [ACTION_W-1:0] ACT_ALLOC_ONE = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_ALLOC_RUN = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_FREE      = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_RESERVE   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CLEAR     = 3'd4;

   localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_PAGE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_COUNT = 1'b1;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [ADDR_W-1:0]   address;
      logic [ADDR_W-1:0]   end_address;
      logic [RUN_W-1:0]    run_length;
      logic [ALIGN_W-1:0]  align_log2;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   result_address;
      logic [STATUS_W-1:0] status;
   } done_type;

endpackage

// File: sv/pba_chan_if.sv
// ----------------------------------------------------------------------------
// pba_req_if / pba_rsp_if
// Valid/ready channels carrying request and response beats.
// ----------------------------------------------------------------------------
interface pba_req_if;
   import pba_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [ADDR_W-1:0]   address;
   logic [ADDR_W-1:0]   end_address;
   logic [RUN_W-1:0]    run_length;
   logic [ALIGN_W-1:0]  align_log2;

   modport source (output valid, action, address, end_address, run_length, align_log2,
                   input ready);
   modport sink   (input valid, action, address, end_address, run_length, align_log2,
                   output ready);
endinterface

interface pba_rsp_if;
   import pba_pkg::*;

   logic                valid;
   logic                ready;
   logic [ADDR_W-1:0]   result_address;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  free_count;

   modport source (output valid, result_address, status, free_count, input ready);
   modport sink   (input valid, result_address, status, free_count, output ready);
endinterface

// File: sv/pba_map_ram.sv
// ----------------------------------------------------------------------------
// pba_map_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pba_map_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

// File: sv/pba_engine.sv
// ----------------------------------------------------------------------------
// pba_engine
// Sequencer that walks the page map one page per cycle, stalling while a map
// word is fetched into a write-through word buffer in front of the map RAM.
// ----------------------------------------------------------------------------
`include "page_bitmap_allocator_unit_assert.svh"

module pba_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  pba_pkg::req_type               req,
   input  logic [pba_pkg::ADDR_W-1:0]     base_pa,
   input  logic [pba_pkg::KW-1:0]         np,
   output logic                           ram_we,
   output logic [pba_pkg::WIDX_W-1:0]     ram_waddr,
   output logic [31:0]                    ram_wdata,
   output logic [pba_pkg::WIDX_W-1:0]     ram_raddr,
   input  logic [31:0]                    ram_rdata,
   output logic                           done_valid,
   input  logic                           done_ready,
   output pba_pkg::done_type              done,
   output logic [pba_pkg::KW-1:0]         used_count
);
   import pba_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_STEP  = 3'd1;
   localparam logic [2:0] S_FETCH = 3'd2;
   localparam logic [2:0] S_LOAD  = 3'd3;
   localparam logic [2:0] S_MARK  = 3'd4;
   localparam logic [2:0] S_FLUSH = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(MAP_WORDS - 1);

   logic [2:0]          state_ff, state_in, ret_ff, ret_in;
   logic [ACTION_W-1:0] op_ff, op_in;
   logic [KW-1:0]       k_ff, k_in, e_ff, e_in, start_ff, start_in, cnt_ff, cnt_in;
   logic [KW-1:0]       used_ff, used_in;
   logic [RUN_W-1:0]    n_ff, n_in;
   logic [31:0]         amask_ff, amask_in;
   logic [ADDR_W-1:0]   res_ff, res_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [31:0]         wbuf_ff, wbuf_in;
   logic [WIDX_W-1:0]   widx_ff, widx_in, fl_ff, fl_in;
   logic                wv_ff, wv_in, boot_ff, boot_in;

   logic [WIDX_W-1:0]   k_word;
   logic                word_ok, cur_bit;
   logic [31:0]         np32, pa_k, free_idx, rs_addr, rs_s, rs_e, rs_ec;

   assign k_word  = k_ff[WIDX_W+4:5];
   assign word_ok = wv_ff && (widx_ff == k_word);
   assign cur_bit = wbuf_ff[k_ff[4:0]];
   assign np32    = 32'(np);
   assign pa_k    = base_pa + (32'(k_ff) << PAGE_BITS);

   assign free_idx = (req.address - base_pa) >> PAGE_BITS;
   assign rs_addr  = (req.address < base_pa) ? base_pa : req.address;
   assign rs_s     = (rs_addr - base_pa) >> PAGE_BITS;
   assign rs_e     = (req.end_address - base_pa + 32'((1 << PAGE_BITS) - 1)) >> PAGE_BITS;
   assign rs_ec    = (rs_e > np32) ? np32 : rs_e;

   assign req_ready  = (state_ff == S_IDLE);
   assign done_valid = (state_ff == S_DONE);
   assign done.result_address = res_ff;
   assign done.status         = status_ff;
   assign used_count          = used_ff;

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      op_in     = op_ff;
      k_in      = k_ff;
      e_in      = e_ff;
      start_in  = start_ff;
      cnt_in    = cnt_ff;
      used_in   = used_ff;
      n_in      = n_ff;
      amask_in  = amask_ff;
      res_in    = res_ff;
      status_in = status_ff;
      wbuf_in   = wbuf_ff;
      widx_in   = widx_ff;
      wv_in     = wv_ff;
      fl_in     = fl_ff;
      boot_in   = boot_ff;
      ram_we    = 1'b0;
      ram_raddr = k_word;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req.action;
               res_in    = '0;
               status_in = ST_DONE;
               cnt_in    = '0;
               n_in      = req.run_length;
               amask_in  = (32'd1 << req.align_log2) - 32'd1;
               k_in      = '0;
               unique case (req.action)
                  ACT_ALLOC_ONE, ACT_ALLOC_RUN: begin
                     state_in = S_STEP;
                  end
                  ACT_FREE: begin
                     if (req.address < base_pa || free_idx >= np32) begin
                        status_in = ST_IGNORED;
                        state_in  = S_DONE;
                     end else begin
                        k_in     = KW'(free_idx);
                        state_in = S_STEP;
                     end
                  end
                  ACT_RESERVE: begin
                     if (req.end_address <= base_pa) begin
                        status_in = ST_IGNORED;
                        state_in  = S_DONE;
                     end else if (rs_s >= rs_ec) begin
                        state_in = S_DONE;
                     end else begin
                        k_in     = KW'(rs_s);
                        e_in     = KW'(rs_ec);
                        state_in = S_STEP;
                     end
                  end
                  ACT_CLEAR: begin
                     fl_in    = '0;
                     boot_in  = 1'b0;
                     state_in = S_FLUSH;
                  end
                  default: begin
                     status_in = ST_IGNORED;
                     state_in  = S_DONE;
                  end
               endcase
            end
         end

         S_STEP: begin
            unique case (op_ff)
               ACT_ALLOC_ONE: begin
                  if (32'(k_ff) >= np32) begin
                     status_in = ST_NOSPACE;
                     state_in  = S_DONE;
                  end else if (!word_ok) begin
                     ret_in   = S_STEP;
                     state_in = S_FETCH;
                  end else if (!cur_bit) begin
                     wbuf_in[k_ff[4:0]] = 1'b1;
                     ram_we   = 1'b1;
                     used_in  = used_ff + KW'(1);
                     res_in   = pa_k;
                     state_in = S_DONE;
                  end else begin
                     k_in = k_ff + KW'(1);
                  end
               end
               ACT_ALLOC_RUN: begin
                  if (cnt_ff == '0) begin
                     if (32'(k_ff) + 32'(n_ff) > np32) begin
                        res_in    = '0;
                        status_in = ST_NOSPACE;
                        state_in  = S_DONE;
                     end else if ((pa_k & amask_ff) != 32'd0) begin
                        k_in = k_ff + KW'(1);
                     end else if (n_ff == '0) begin
                        res_in   = pa_k;
                        state_in = S_DONE;
                     end else if (!word_ok) begin
                        ret_in   = S_STEP;
                        state_in = S_FETCH;
                     end else if (cur_bit) begin
                        k_in = k_ff + KW'(1);
                     end else begin
                        start_in = k_ff;
                        res_in   = pa_k;
                        if (n_ff == RUN_W'(1)) begin
                           e_in     = k_ff + KW'(1);
                           state_in = S_MARK;
                        end else begin
                           cnt_in = KW'(1);
                           k_in   = k_ff + KW'(1);
                        end
                     end
                  end else begin
                     if (!word_ok) begin
                        ret_in   = S_STEP;
                        state_in = S_FETCH;
                     end else if (cur_bit) begin
                        cnt_in = '0;
                        k_in   = k_ff + KW'(1);
                     end else if (32'(cnt_ff) + 32'd1 == 32'(n_ff)) begin
                        k_in     = start_ff;
                        e_in     = start_ff + KW'(n_ff);
                        state_in = S_MARK;
                     end else begin
                        cnt_in = cnt_ff + KW'(1);
                        k_in   = k_ff + KW'(1);
                     end
                  end
               end
               ACT_FREE: begin
                  if (!word_ok) begin
                     ret_in   = S_STEP;
                     state_in = S_FETCH;
                  end else if (cur_bit) begin
                     wbuf_in[k_ff[4:0]] = 1'b0;
                     ram_we   = 1'b1;
                     used_in  = used_ff - KW'(1);
                     state_in = S_DONE;
                  end else begin
                     status_in = ST_IGNORED;
                     state_in  = S_DONE;
                  end
               end
               ACT_RESERVE: begin
                  if (k_ff == e_ff) begin
                     state_in = S_DONE;
                  end else if (!word_ok) begin
                     ret_in   = S_STEP;
                     state_in = S_FETCH;
                  end else begin
                     if (!cur_bit) begin
                        wbuf_in[k_ff[4:0]] = 1'b1;
                        ram_we  = 1'b1;
                        used_in = used_ff + KW'(1);
                     end
                     k_in = k_ff + KW'(1);
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         S_MARK: begin
            if (k_ff == e_ff) begin
               state_in = S_DONE;
            end else if (!word_ok) begin
               ret_in   = S_MARK;
               state_in = S_FETCH;
            end else begin
               wbuf_in[k_ff[4:0]] = 1'b1;
               ram_we  = 1'b1;
               used_in = used_ff + KW'(1);
               k_in    = k_ff + KW'(1);
            end
         end

         S_FETCH: begin
            state_in = S_LOAD;
         end

         S_LOAD: begin
            wbuf_in  = ram_rdata;
            widx_in  = k_word;
            wv_in    = 1'b1;
            state_in = ret_ff;
         end

         S_FLUSH: begin
            ram_we  = 1'b1;
            wv_in   = 1'b0;
            used_in = '0;
            if (fl_ff == LAST_WORD) begin
               state_in = boot_ff ? S_IDLE : S_DONE;
            end else begin
               fl_in = fl_ff + WIDX_W'(1);
            end
         end

         S_DONE: begin
            if (done_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      ram_waddr = (state_ff == S_FLUSH) ? fl_ff : widx_ff;
      ram_wdata = (state_ff == S_FLUSH) ? 32'd0 : wbuf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_FLUSH;
         fl_ff    <= '0;
         boot_ff  <= 1'b1;
         wv_ff    <= 1'b0;
         used_ff  <= '0;
         ret_ff   <= S_STEP;
         op_ff    <= ACT_ALLOC_ONE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fl_ff    <= fl_in;
         boot_ff  <= boot_in;
         wv_ff    <= wv_in;
         used_ff  <= used_in;
         ret_ff   <= ret_in;
         op_ff    <= op_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      e_ff      <= e_in;
      start_ff  <= start_in;
      n_ff      <= n_in;
      amask_ff  <= amask_in;
      res_ff    <= res_in;
      status_ff <= status_in;
      wbuf_ff   <= wbuf_in;
      widx_ff   <= widx_in;
   end

   `PBA_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && req_ready, state_ff != S_IDLE, "accepted beat did not start work")
   `PBA_ASSERT_NOW(a_write_in_work, clock, reset, ram_we, state_ff == S_STEP || state_ff == S_MARK || state_ff == S_FLUSH, "map write outside a work state")
   `PBA_ASSERT_NOW(a_mark_free_page, clock, reset, state_ff == S_MARK && word_ok && k_ff != e_ff, !cur_bit, "run marks a used page")
   `PBA_ASSERT_NOW(a_used_bounded, clock, reset, 1'b1, 32'(used_ff) <= 32'(MAP_PAGES), "used count beyond map")

endmodule

// File: sv/page_bitmap_allocator_unit.sv
// ----------------------------------------------------------------------------
// page_bitmap_allocator_unit
// Bitmap page-frame allocator: one used bit per page, kept in a word RAM,
// scanned by a single sequencer one page per cycle, stalling on word fetches.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake      | beat contents
//  req_chan | in  | valid / ready  | action, address, end_address, run_length, align_log2
//  rsp_chan | out | valid / ready  | result_address, status, free_count
//  csr_*    | in  | write enable   | index 0 base_page, index 1 page_count
//
//  Scan: one page per cycle while the page's map word is in the word buffer;
//  a word is brought into the word buffer through the step that misses, FETCH
//  and LOAD. An allocated run is then marked in a second pass over its pages.
//  Free: decided in STEP, after FETCH and LOAD when its word is not buffered.
//  Clear sweeps all MAP_WORDS words of the map RAM to zero.
//  Reset: synchronous; after reset the map RAM is swept to zero word by word
//  with req_chan.ready low. CSR writes are taken throughout.
//  Stalls: one request in flight; the response register frees the engine, so
//  the next request is taken while a response still waits.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_unit (
   input  logic                          clock,
   input  logic                          reset,
   pba_req_if.sink                       req_chan,
   pba_rsp_if.source                     rsp_chan,
   input  logic                          csr_write_en,
   input  logic [pba_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pba_pkg::CSR_DW-1:0]    csr_wdata
);
   import pba_pkg::*;

   // configuration registers
   logic [BASE_W-1:0]  base_page_ff;
   logic [COUNT_W-1:0] page_count_ff;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   rsp_addr_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [COUNT_W-1:0]  rsp_free_ff;

   logic [ADDR_W-1:0]  base_pa;
   logic [KW-1:0]      np;
   logic [KW-1:0]      used_count;
   req_type            req;
   done_type           done;
   logic               done_valid, done_ready;

   logic               ram_we;
   logic [WIDX_W-1:0]  ram_waddr, ram_raddr;
   logic [31:0]        ram_wdata, ram_rdata;

   // physical address of page index zero; wraps to 32 bits
   assign base_pa = ADDR_W'({base_page_ff, {PAGE_BITS{1'b0}}});
   // effective page count, clamped to the map depth
   assign np = (32'(page_count_ff) > 32'(MAP_PAGES)) ? KW'(MAP_PAGES) : KW'(page_count_ff);

   assign req.action      = req_chan.action;
   assign req.address     = req_chan.address;
   assign req.end_address = req_chan.end_address;
   assign req.run_length  = req_chan.run_length;
   assign req.align_log2  = req_chan.align_log2;

   // engine may hand over a result when the response slot is empty or draining
   assign done_ready   = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_valid_in = (done_valid && done_ready) ||
                         (rsp_valid_ff && !rsp_chan.ready);

   pba_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req        (req),
      .base_pa    (base_pa),
      .np         (np),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .done_valid (done_valid),
      .done_ready (done_ready),
      .done       (done),
      .used_count (used_count)
   );

   pba_map_ram #(
      .DEPTH (MAP_WORDS),
      .WIDTH (32)
   ) u_map_ram (
      .clock      (clock),
      .wr_en      (ram_we),
      .wr_addr    (ram_waddr),
      .wr_data    (ram_wdata),
      .rd_addr    (ram_raddr),
      .rd_data_ff (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         base_page_ff  <= '0;
         page_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_BASE_PAGE:  base_page_ff  <= csr_wdata[BASE_W-1:0];
               CSR_PAGE_COUNT: page_count_ff <= csr_wdata[COUNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // response payload; free count floors at zero when page_count was lowered
   always_ff @(posedge clock) begin
      if (done_valid && done_ready) begin
         rsp_addr_ff   <= done.result_address;
         rsp_status_ff <= done.status;
         rsp_free_ff   <= (np > used_count) ? COUNT_W'(np - used_count) : '0;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.result_address = rsp_addr_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.free_count     = rsp_free_ff;

endmodule
